@@ design/assert_macros.svh @@
// Assertion macros used by the mapper core, cbm_core.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/cbm_pkg.sv @@
// Package for the cartridge bank mapper: item types, kind codes, write decode constants.
// No dependencies.
package cbm_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int ROM_W  = 21;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CPU   = 2'd2;
    localparam logic [1:0] KIND_PPU   = 2'd3;

    localparam logic [15:0] DEC_MASK     = 16'hF80C;
    localparam logic [15:0] DEC_CHR_LO   = 16'hB000;
    localparam logic [15:0] DEC_CHR_HI   = 16'hE00C;
    localparam logic [15:0] DEC_PRG0     = 16'h8800;
    localparam logic [15:0] DEC_PRG1     = 16'hA800;
    localparam logic [15:0] DEC_PRG2     = 16'hA000;
    localparam logic [15:0] DEC_MIRROR   = 16'h9800;
    localparam logic [15:0] DEC_CNT_LO   = 16'hF000;
    localparam logic [15:0] DEC_CNT_HI   = 16'hF004;
    localparam logic [15:0] DEC_IRQ_CTRL = 16'hF008;
    localparam logic [15:0] DEC_IRQ_OFS  = 16'hF00C;

    localparam logic [7:0] IRQ_MATCH     = 8'd238;
    localparam logic [7:0] IRQ_MATCH_OFS = 8'd254;
    localparam logic [7:0] BANK_LAST     = 8'd255;

    // CPU window codes, address bits 15..13
    localparam logic [2:0] WIN_6000 = 3'd3;
    localparam logic [2:0] WIN_8000 = 3'd4;
    localparam logic [2:0] WIN_A000 = 3'd5;
    localparam logic [2:0] WIN_C000 = 3'd6;
    localparam logic [2:0] WIN_E000 = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } cbm_in_t;

    typedef struct packed {
        logic [ROM_W-1:0] rom_addr;
        logic             irq_pending;
        logic [1:0]       mirror_mode;
    } cbm_out_t;

endpackage

@@ design/cartridge_bank_mapper_irq_top.sv @@
// Top level of the cartridge bank mapper: input register, mapper core, result register.
// Depends on cbm_pkg and cbm_core.
//
//  channel | signals                          | payload
//  input   | in_valid / in_ready / in_item    | cbm_in_t  kind, address, data
//  output  | out_valid / out_ready / out_item | cbm_out_t rom_addr, irq_pending, mirror_mode
//
// One item per cycle sustained while out_ready is high; an accepted item passes through the
// input register and then the result register before out_valid rises for its result.
// The input register and the result register sit around one decode pass in the core.
// Reset clears all bank, mirroring and irq state and empties both stages.
// A stalled result holds the result register; the input register then holds its item
// and in_ready drops only when both stages are full and the result is not taken.

module cartridge_bank_mapper_irq_top
    import cbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cbm_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output cbm_out_t out_item
);

    logic     in_v_reg;
    cbm_in_t  in_item_reg;
    logic     out_v_reg;
    cbm_out_t out_item_reg;
    cbm_out_t result;
    logic     out_free;
    logic     fire;

    assign out_free = !out_v_reg || out_ready;
    assign fire     = in_v_reg && out_free;
    assign in_ready = !in_v_reg || out_free;

    cbm_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_v_reg <= in_valid;
            if (out_free)
                out_v_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (fire)
            out_item_reg <= result;
    end

    assign out_valid = out_v_reg;
    assign out_item  = out_item_reg;

endmodule

@@ design/cbm_core.sv @@
// Mapper state and per-item logic: write decode, scanline counter, address translation.
// Depends on cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbm_core
    import cbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  cbm_in_t  item,
    output cbm_out_t result
);

    logic [7:0] prg0_reg, prg1_reg, prg2_reg;
    logic [7:0] prg0_next, prg1_next, prg2_next;
    logic [7:0] chr_bank_reg  [8];
    logic [7:0] chr_bank_next [8];
    logic [7:0] irq_counter_reg, irq_counter_next;
    logic       irq_offset_on_reg, irq_offset_on_next;
    logic       irq_enable_reg, irq_enable_next;
    logic       irq_line_reg, irq_line_next;
    logic [1:0] mirroring_reg, mirroring_next;

    logic [15:0] dec;
    logic        chr_hit;
    logic [2:0]  chr_idx;
    logic [7:0]  cpu_bank;
    logic [ROM_W-1:0] rom;

    assign dec     = item.address & DEC_MASK;
    assign chr_hit = (dec >= DEC_CHR_LO) && (dec <= DEC_CHR_HI);
    assign chr_idx = (item.address[13:11] - 3'd6) | item.address[5:3];

    always_comb
    begin
        prg0_next          = prg0_reg;
        prg1_next          = prg1_reg;
        prg2_next          = prg2_reg;
        irq_counter_next   = irq_counter_reg;
        irq_offset_on_next = irq_offset_on_reg;
        irq_enable_next    = irq_enable_reg;
        irq_line_next      = irq_line_reg;
        mirroring_next     = mirroring_reg;
        for (int i = 0; i < 8; i++)
        begin
            chr_bank_next[i] = chr_bank_reg[i];
            if (item.kind == KIND_WRITE && chr_hit && chr_idx == 3'(i))
            begin
                if (item.address[2])
                    chr_bank_next[i] = {item.data[3:0], chr_bank_reg[i][3:0]};
                else
                    chr_bank_next[i] = {chr_bank_reg[i][7:4], item.data[3:0]};
            end
        end
        if (item.kind == KIND_WRITE && !chr_hit)
        begin
            case (dec)
                DEC_PRG0:   prg0_next = item.data;
                DEC_PRG1:   prg1_next = item.data;
                DEC_PRG2:   prg2_next = item.data;
                DEC_MIRROR: mirroring_next = item.data[1:0];
                DEC_CNT_LO: irq_counter_next = {irq_counter_reg[7:4], item.data[3:0]};
                DEC_CNT_HI: irq_counter_next = {item.data[3:0], irq_counter_reg[3:0]};
                DEC_IRQ_CTRL:
                begin
                    irq_enable_next = (item.data != '0);
                    if (item.data == '0)
                        irq_offset_on_next = 1'b0;
                    irq_line_next = 1'b0;
                end
                DEC_IRQ_OFS: irq_offset_on_next = 1'b1;
                default: ;
            endcase
        end
        else if (item.kind == KIND_TICK && irq_enable_reg)
        begin
            irq_counter_next = irq_counter_reg + 8'd1;
            if (irq_counter_next == (irq_offset_on_reg ? IRQ_MATCH_OFS : IRQ_MATCH))
                irq_line_next = 1'b1;
        end
    end

    always_comb
    begin
        case (item.address[15:13])
            WIN_6000: cpu_bank = '0;
            WIN_8000: cpu_bank = prg0_reg;
            WIN_A000: cpu_bank = prg1_reg;
            WIN_C000: cpu_bank = prg2_reg;
            WIN_E000: cpu_bank = BANK_LAST;
            default:  cpu_bank = '0;
        endcase
        rom = '0;
        case (item.kind)
            KIND_CPU:
            begin
                if (item.address[15:13] >= WIN_6000)
                    rom = {cpu_bank, item.address[12:0]};
            end
            KIND_PPU:
            begin
                if (item.address[15:13] == 3'd0)
                    rom = ROM_W'({chr_bank_reg[item.address[12:10]], item.address[9:0]});
            end
            default: rom = '0;
        endcase
    end

    // results see the state as this item leaves it
    assign result.rom_addr    = rom;
    assign result.irq_pending = irq_line_next;
    assign result.mirror_mode = mirroring_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg0_reg          <= '0;
            prg1_reg          <= '0;
            prg2_reg          <= '0;
            irq_counter_reg   <= '0;
            irq_offset_on_reg <= 1'b0;
            irq_enable_reg    <= 1'b0;
            irq_line_reg      <= 1'b0;
            mirroring_reg     <= '0;
            for (int i = 0; i < 8; i++)
                chr_bank_reg[i] <= '0;
        end
        else if (fire)
        begin
            prg0_reg          <= prg0_next;
            prg1_reg          <= prg1_next;
            prg2_reg          <= prg2_next;
            irq_counter_reg   <= irq_counter_next;
            irq_offset_on_reg <= irq_offset_on_next;
            irq_enable_reg    <= irq_enable_next;
            irq_line_reg      <= irq_line_next;
            mirroring_reg     <= mirroring_next;
            for (int i = 0; i < 8; i++)
                chr_bank_reg[i] <= chr_bank_next[i];
        end
    end

    `ASSERT_NEXT(a_cnt_hold, clk, rst_n, !fire, $stable(irq_counter_reg), "irq counter moved without an item")
    `ASSERT_IMPLY(a_irq_src, clk, rst_n, $rose(irq_line_reg), $past(fire && item.kind == KIND_TICK), "irq raised by a non-tick item")
    `ASSERT_NEXT(a_irq_ack, clk, rst_n, fire && item.kind == KIND_WRITE && dec == DEC_IRQ_CTRL, !irq_line_reg, "irq not cleared by acknowledge")
    `ASSERT_NEXT(a_no_en_tick, clk, rst_n, fire && item.kind == KIND_TICK && !irq_enable_reg, $stable(irq_counter_reg) && $stable(irq_line_reg), "tick moved a disabled counter")

endmodule
